@@ hw/rtl/tsd_pkg.sv @@
// shared types and constants for the two-stack deque
// no dependencies; imported by tsd_ram users, tsd_ctrl and two_stack_deque
package tsd_pkg;

   localparam int SIDE_DEPTH = 256;
   localparam int DATA_W     = 32;
   localparam int ADDR_W     = $clog2(SIDE_DEPTH);
   localparam int COUNT_W    = $clog2(SIDE_DEPTH + 1);
   localparam int TOTAL_W    = COUNT_W + 1;
   localparam int POS_W      = 9;
   localparam int KIND_W     = 3;
   localparam int STATUS_W   = 2;
   localparam int IN_DATA_W  = ((DATA_W + POS_W + 7) / 8) * 8;
   localparam int OUT_BITS   = DATA_W + STATUS_W + TOTAL_W + 1;
   localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

   localparam logic [COUNT_W-1:0] SIDE_FULL = COUNT_W'(SIDE_DEPTH);

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_FRONT = 3'd0,
      KIND_PUSH_BACK  = 3'd1,
      KIND_READ_AT    = 3'd2,
      KIND_READ_FRONT = 3'd3,
      KIND_READ_BACK  = 3'd4
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SRC_NONE  = 2'd0,
      SRC_FRONT = 2'd1,
      SRC_BACK  = 2'd2
   } src_type;

   typedef struct packed {
      logic              en;
      logic              we;
      logic [ADDR_W-1:0] addr;
   } ram_cmd_type;

   typedef struct packed {
      src_type            src;
      status_type         status;
      logic [TOTAL_W-1:0] total;
      logic               empty;
   } rsp_info_type;

endpackage

@@ hw/rtl/tsd_ram.sv @@
// single-port synchronous ram, registered read
// generic; no package dependencies
module tsd_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en && we) begin
         mem[addr] <= wdata;
      end
      // read data holds until the next read
      if (en && !we) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/tsd_ctrl.sv @@
// request decode, side counts and stack addressing for the two-stack deque
// depends on tsd_pkg
module tsd_ctrl import tsd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [KIND_W-1:0]  kind,
   input  logic [POS_W-1:0]   position,
   output ram_cmd_type        front_cmd,
   output ram_cmd_type        back_cmd,
   output rsp_info_type       info
);

   logic [COUNT_W-1:0] front_count_ff, front_count_in;
   logic [COUNT_W-1:0] back_count_ff, back_count_in;
   logic [TOTAL_W-1:0] total_now;
   logic [TOTAL_W-1:0] total_after;
   logic [COUNT_W-1:0] front_off;
   logic [COUNT_W-1:0] back_off;
   ram_cmd_type        front_raw;
   ram_cmd_type        back_raw;
   src_type            src;
   status_type         status;

   assign total_now = {1'b0, front_count_ff} + {1'b0, back_count_ff};
   // index below the front count walks down the front stack, else up the back
   assign front_off = front_count_ff - COUNT_W'(1) - COUNT_W'(position);
   assign back_off  = COUNT_W'(position) - front_count_ff;

   always_comb begin
      front_count_in = front_count_ff;
      back_count_in  = back_count_ff;
      front_raw      = '0;
      back_raw       = '0;
      src            = SRC_NONE;
      status         = ST_OK;
      unique case (req_kind_type'(kind))
         KIND_PUSH_FRONT: begin
            if (front_count_ff == SIDE_FULL) begin
               status = ST_FULL;
            end else begin
               front_raw      = '{en: 1'b1, we: 1'b1, addr: front_count_ff[ADDR_W-1:0]};
               front_count_in = front_count_ff + COUNT_W'(1);
            end
         end
         KIND_PUSH_BACK: begin
            if (back_count_ff == SIDE_FULL) begin
               status = ST_FULL;
            end else begin
               back_raw      = '{en: 1'b1, we: 1'b1, addr: back_count_ff[ADDR_W-1:0]};
               back_count_in = back_count_ff + COUNT_W'(1);
            end
         end
         KIND_READ_AT: begin
            if (TOTAL_W'(position) >= total_now) begin
               status = ST_RANGE;
            end else if (COUNT_W'(position) < front_count_ff) begin
               front_raw = '{en: 1'b1, we: 1'b0, addr: front_off[ADDR_W-1:0]};
               src       = SRC_FRONT;
            end else begin
               back_raw = '{en: 1'b1, we: 1'b0, addr: back_off[ADDR_W-1:0]};
               src      = SRC_BACK;
            end
         end
         KIND_READ_FRONT: begin
            if (front_count_ff != '0) begin
               front_raw = '{en: 1'b1, we: 1'b0,
                             addr: ADDR_W'(front_count_ff - COUNT_W'(1))};
               src       = SRC_FRONT;
            end else if (back_count_ff != '0) begin
               back_raw = '{en: 1'b1, we: 1'b0, addr: '0};
               src      = SRC_BACK;
            end else begin
               status = ST_RANGE;
            end
         end
         KIND_READ_BACK: begin
            if (back_count_ff != '0) begin
               back_raw = '{en: 1'b1, we: 1'b0,
                            addr: ADDR_W'(back_count_ff - COUNT_W'(1))};
               src      = SRC_BACK;
            end else if (front_count_ff != '0) begin
               front_raw = '{en: 1'b1, we: 1'b0, addr: '0};
               src       = SRC_FRONT;
            end else begin
               status = ST_RANGE;
            end
         end
         default: begin
            status = ST_RANGE;
         end
      endcase
   end

   assign total_after = {1'b0, front_count_in} + {1'b0, back_count_in};

   always_comb begin
      front_cmd    = front_raw;
      back_cmd     = back_raw;
      front_cmd.en = front_raw.en & accept;
      back_cmd.en  = back_raw.en & accept;
      info.src     = src;
      info.status  = status;
      info.total   = total_after;
      info.empty   = (total_after == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_count_ff <= '0;
         back_count_ff  <= '0;
      end else if (accept) begin
         front_count_ff <= front_count_in;
         back_count_ff  <= back_count_in;
      end
   end

endmodule

@@ hw/rtl/two_stack_deque.sv @@
// top level of the two-stack deque: stream ports, two stack rams, result register
// depends on tsd_pkg, tsd_ram and tsd_ctrl
//
// Double-ended queue held in two stacks of SIDE_DEPTH entries each: the front
// stack grows toward the front, the back stack toward the back. A request
// (kind in req_tuser) pushes at either end, reads at a logical index, or reads
// the front or back element; each request yields exactly one result
// transaction carrying read data, status, total count and an empty flag. A
// push onto a full side is dropped with status 2; a read past the end or of
// an empty deque gives status 1 and zero data. Side counts are updated at the
// accept edge, and the one stack access of a request happens there too; the
// ram's registered read data is picked up into the result register when the
// read stage advances. The pipeline is two deep (ram read stage, result
// register), so a new request is taken every cycle while rsp_tready is high.
// rsp_tvalid for a request rises at the edge where its read stage advances.
// Push-then-read of the same entry needs no forwarding: the write lands at
// the accept edge, before any later read is issued. No clearing pass after
// reset.
module two_stack_deque import tsd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [IN_DATA_W-1:0]  req_tdata,   // value[31:0], position[40:32], zero pad
   input  logic [KIND_W-1:0]     req_tuser,   // req_type[2:0]
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [OUT_DATA_W-1:0] rsp_tdata    // read_data[31:0], status[33:32],
                                              // total_count[43:34], is_empty[44], zero pad
);

   logic             accept;
   logic             advance;
   ram_cmd_type      front_cmd;
   ram_cmd_type      back_cmd;
   rsp_info_type     info;
   logic [DATA_W-1:0] front_rdata;
   logic [DATA_W-1:0] back_rdata;
   logic [DATA_W-1:0] wdata;
   logic [DATA_W-1:0] read_data;

   // ram read stage
   logic             s1_valid_ff, s1_valid_in;
   rsp_info_type     s1_info_ff;
   // result register
   logic                  out_valid_ff, out_valid_in;
   logic [OUT_DATA_W-1:0] out_data_ff, out_data_in;

   // read stage moves on whenever the result register is free or draining
   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign wdata = req_tdata[DATA_W-1:0];

   tsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .kind      (req_tuser),
      .position  (req_tdata[DATA_W +: POS_W]),
      .front_cmd (front_cmd),
      .back_cmd  (back_cmd),
      .info      (info)
   );

   tsd_ram #(.DEPTH(SIDE_DEPTH), .WIDTH(DATA_W)) u_front_ram (
      .clock (clock),
      .en    (front_cmd.en),
      .we    (front_cmd.we),
      .addr  (front_cmd.addr),
      .wdata (wdata),
      .rdata (front_rdata)
   );

   tsd_ram #(.DEPTH(SIDE_DEPTH), .WIDTH(DATA_W)) u_back_ram (
      .clock (clock),
      .en    (back_cmd.en),
      .we    (back_cmd.we),
      .addr  (back_cmd.addr),
      .wdata (wdata),
      .rdata (back_rdata)
   );

   // ram read data holds until the next accepted read, so a stalled stage is safe
   always_comb begin
      case (s1_info_ff.src)
         SRC_FRONT: read_data = front_rdata;
         SRC_BACK:  read_data = back_rdata;
         default:   read_data = '0;
      endcase
   end

   always_comb begin
      s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      out_data_in = OUT_DATA_W'({s1_info_ff.empty, s1_info_ff.total,
                                 s1_info_ff.status, read_data});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= info;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
